/* hw/rtl/vbd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbd_pkg
// Shared types, constants and format helpers for the vertical box downscaler.
// ----------------------------------------------------------------------------
package vbd_pkg;

    localparam int MaxRowElements = 4096;
    localparam int AddrWidth      = $clog2(MaxRowElements);
    localparam int SumWidth       = 49;
    localparam int RndWidth       = SumWidth + 1;
    localparam int SampleWidth    = 33;
    localparam int FactorWidth    = 16;
    localparam int FormatWidth    = 3;
    localparam int LengthWidth    = 13;
    localparam int CfgDataWidth   = 16;
    localparam int CfgIndexWidth  = 2;
    localparam int DivSteps       = RndWidth;
    localparam int DivCountWidth  = $clog2(DivSteps + 1);
    localparam int FixShift       = 24;
    localparam int MultWidth      = FixShift + 1;

    localparam logic [CfgIndexWidth-1:0] REG_SHRINK_FACTOR = 2'd0;
    localparam logic [CfgIndexWidth-1:0] REG_SAMPLE_FORMAT = 2'd1;
    localparam logic [CfgIndexWidth-1:0] REG_ROW_LENGTH    = 2'd2;

    localparam logic [FormatWidth-1:0] FMT_U8  = 3'd0;
    localparam logic [FormatWidth-1:0] FMT_S8  = 3'd1;
    localparam logic [FormatWidth-1:0] FMT_U16 = 3'd2;
    localparam logic [FormatWidth-1:0] FMT_S16 = 3'd3;
    localparam logic [FormatWidth-1:0] FMT_U32 = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIV,
        ST_MUL,
        ST_RESULT
    } state_t;

    // Take the low 8, 16 or 32 bits, zero or sign extended per format.
    function automatic logic [SampleWidth-1:0] fit_format(
        input logic [SampleWidth-1:0] v,
        input logic [FormatWidth-1:0] fmt
    );
        logic [SampleWidth-1:0] r;
        case (fmt)
            FMT_U8:  r = {25'b0, v[7:0]};
            FMT_S8:  r = {{25{v[7]}}, v[7:0]};
            FMT_U16: r = {17'b0, v[15:0]};
            FMT_S16: r = {{17{v[15]}}, v[15:0]};
            FMT_U32: r = {1'b0, v[31:0]};
            default: r = {v[31], v[31:0]};
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/vertical_box_downscale.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertical_box_downscale
// Averages groups of shrink_factor rows column by column into one output row.
//
// Samples enter in raster order on the in_valid / in_ready request channel,
// one band element per request. Each column keeps a running sum in a
// 4096-entry synchronous RAM; an item reads its entry when accepted and
// writes it back on the next cycle. Items on the last row of a group produce
// one average on the out_valid / out_ready channel, with row_end marking the
// last element of the output row; other items produce nothing.
// An item is taken only in the idle state, so the next one waits until it is
// through: non-final rows pass the update step; on the final row the serial
// divider follows (u8 adds a fixed-point multiply step), then the result step.
// The result sits in an output register; a stalled receiver holds it there
// while the next item is already taken and worked on, and that item waits
// at its result step until the register frees.
// Reset clears the row and column counters and loads the default registers
// (factor 2, u8, row length 4096). RAM contents are not cleared; the first
// row of each group writes its entries fresh. Configure only while idle.
// ----------------------------------------------------------------------------
module vertical_box_downscale (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [vbd_pkg::CfgIndexWidth-1:0]      cfg_index,
    input  logic [vbd_pkg::CfgDataWidth-1:0]       cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [vbd_pkg::SampleWidth-1:0] sample,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [vbd_pkg::SampleWidth-1:0] average,
    output logic                                   row_end
);

    logic [vbd_pkg::FactorWidth-1:0]  factor_reg;
    logic [vbd_pkg::FormatWidth-1:0]  format_reg;
    logic [vbd_pkg::LengthWidth-1:0]  length_reg;

    vbd_pkg::state_t state_reg, state_next;

    logic [vbd_pkg::AddrWidth-1:0]    col_reg;
    logic [vbd_pkg::FactorWidth-1:0]  row_reg;
    logic [vbd_pkg::AddrWidth-1:0]    idx_reg;
    logic signed [vbd_pkg::SampleWidth-1:0] v_reg;
    logic                             first_reg;
    logic                             last_row_reg;
    logic                             last_col_reg;
    logic signed [vbd_pkg::RndWidth-1:0] t_reg;
    logic [31:0]                      prod_reg;

    logic signed [vbd_pkg::SampleWidth-1:0] avg_reg;
    logic                             end_reg;
    logic                             out_valid_reg;

    logic                             accept;
    logic                             load_out;
    logic                             mem_we;
    logic signed [vbd_pkg::SumWidth-1:0] rdata;
    logic signed [vbd_pkg::SumWidth-1:0] s_new;
    logic signed [vbd_pkg::RndWidth-1:0] t_new;
    logic [vbd_pkg::FactorWidth-1:0]  f_eff;
    logic [vbd_pkg::LengthWidth-1:0]  len_eff;
    logic                             last_col;
    logic                             last_row;
    logic                             is_u8;
    logic [vbd_pkg::RndWidth-1:0]     div_dividend;
    logic [vbd_pkg::RndWidth-1:0]     quotient;
    logic [vbd_pkg::RndWidth-1:0]     q_signed;
    logic [vbd_pkg::SampleWidth-1:0]  result;
    logic                             div_start;
    logic                             div_done;

    // effective configuration
    assign f_eff   = (factor_reg == '0) ? vbd_pkg::FactorWidth'(1) : factor_reg;
    assign len_eff = (length_reg == '0) ? vbd_pkg::LengthWidth'(1)
                   : (length_reg > vbd_pkg::LengthWidth'(vbd_pkg::MaxRowElements))
                     ? vbd_pkg::LengthWidth'(vbd_pkg::MaxRowElements) : length_reg;
    assign is_u8   = format_reg == vbd_pkg::FMT_U8;

    assign last_col = ({1'b0, col_reg} + 1'b1) >= len_eff;
    assign last_row = ({1'b0, row_reg} + 1'b1) >= {1'b0, f_eff};

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg <= vbd_pkg::FactorWidth'(2);
            format_reg <= vbd_pkg::FMT_U8;
            length_reg <= vbd_pkg::LengthWidth'(vbd_pkg::MaxRowElements);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                vbd_pkg::REG_SHRINK_FACTOR: factor_reg <= cfg_data;
                vbd_pkg::REG_SAMPLE_FORMAT:
                    format_reg <= cfg_data[vbd_pkg::FormatWidth-1:0];
                vbd_pkg::REG_ROW_LENGTH:
                    length_reg <= cfg_data[vbd_pkg::LengthWidth-1:0];
                default: ;
            endcase
        end
    end

    vbd_sum_ram u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (idx_reg),
        .wdata (s_new),
        .re    (accept),
        .raddr (col_reg),
        .rdata (rdata)
    );

    // first row of a group starts fresh, later rows accumulate
    assign s_new = first_reg ? vbd_pkg::SumWidth'(v_reg)
                             : rdata + vbd_pkg::SumWidth'(v_reg);
    assign t_new = vbd_pkg::RndWidth'(s_new) + vbd_pkg::RndWidth'(f_eff >> 1);

    // u8 divides 2^24 by the factor to get the reciprocal; others divide |t|
    assign div_dividend = is_u8 ? (vbd_pkg::RndWidth'(1) << vbd_pkg::FixShift)
                        : (t_new[vbd_pkg::RndWidth-1] ? vbd_pkg::RndWidth'(-t_new)
                                                      : vbd_pkg::RndWidth'(t_new));

    vbd_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (f_eff),
        .done     (div_done),
        .quotient (quotient)
    );

    assign q_signed = t_reg[vbd_pkg::RndWidth-1] ? vbd_pkg::RndWidth'(-quotient) : quotient;
    assign result   = is_u8 ? vbd_pkg::SampleWidth'(prod_reg[31:vbd_pkg::FixShift])
                    : vbd_pkg::fit_format(q_signed[vbd_pkg::SampleWidth-1:0], format_reg);

    assign load_out = (state_reg == vbd_pkg::ST_RESULT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vbd_pkg::ST_IDLE:
                if (accept)
                begin
                    state_next = vbd_pkg::ST_UPDATE;
                end
            vbd_pkg::ST_UPDATE:
                state_next = last_row_reg ? vbd_pkg::ST_DIV : vbd_pkg::ST_IDLE;
            vbd_pkg::ST_DIV:
                if (div_done)
                begin
                    state_next = is_u8 ? vbd_pkg::ST_MUL : vbd_pkg::ST_RESULT;
                end
            vbd_pkg::ST_MUL:
                state_next = vbd_pkg::ST_RESULT;
            vbd_pkg::ST_RESULT:
                if (load_out)
                begin
                    state_next = vbd_pkg::ST_IDLE;
                end
            default:
                state_next = vbd_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = state_reg == vbd_pkg::ST_IDLE;
        mem_we    = state_reg == vbd_pkg::ST_UPDATE;
        div_start = (state_reg == vbd_pkg::ST_UPDATE) && last_row_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vbd_pkg::ST_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // advance the raster position as each item is taken
            if (accept)
            begin
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + 1'b1;
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg      <= col_reg;
            v_reg        <= vbd_pkg::fit_format(sample, format_reg);
            first_reg    <= row_reg == '0;
            last_row_reg <= last_row;
            last_col_reg <= last_col;
        end
        if (state_reg == vbd_pkg::ST_UPDATE)
        begin
            t_reg <= t_new;
        end
        if (state_reg == vbd_pkg::ST_MUL)
        begin
            prod_reg <= 32'(t_reg[31:0] * quotient[vbd_pkg::MultWidth-1:0]);
        end
        if (load_out)
        begin
            avg_reg <= result;
            end_reg <= last_col_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign average   = avg_reg;
    assign row_end   = end_reg;

endmodule

/* hw/rtl/vbd_sum_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbd_sum_ram
// Column sum store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module vbd_sum_ram (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [vbd_pkg::AddrWidth-1:0]            waddr,
    input  logic signed [vbd_pkg::SumWidth-1:0]      wdata,
    input  logic                                     re,
    input  logic [vbd_pkg::AddrWidth-1:0]            raddr,
    output logic signed [vbd_pkg::SumWidth-1:0]      rdata
);

    logic signed [vbd_pkg::SumWidth-1:0] mem [vbd_pkg::MaxRowElements];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hw/rtl/vbd_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbd_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vbd_divider (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [vbd_pkg::RndWidth-1:0]       dividend,
    input  logic [vbd_pkg::FactorWidth-1:0]    divisor,
    output logic                               done,
    output logic [vbd_pkg::RndWidth-1:0]       quotient
);

    logic [vbd_pkg::RndWidth-1:0]      quo_reg;
    logic [vbd_pkg::FactorWidth-1:0]   rem_reg;
    logic [vbd_pkg::FactorWidth-1:0]   div_reg;
    logic [vbd_pkg::DivCountWidth-1:0] cnt_reg;
    logic                              busy_reg;
    logic                              done_reg;
    logic [vbd_pkg::FactorWidth:0]     trial;
    logic                              fits;

    assign trial = {rem_reg, quo_reg[vbd_pkg::RndWidth-1]};
    assign fits  = trial >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == vbd_pkg::DivCountWidth'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= vbd_pkg::DivCountWidth'(vbd_pkg::DivSteps);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == vbd_pkg::DivCountWidth'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when it fits
            quo_reg <= {quo_reg[vbd_pkg::RndWidth-2:0], fits};
            rem_reg <= fits ? vbd_pkg::FactorWidth'(trial - {1'b0, div_reg})
                            : vbd_pkg::FactorWidth'(trial);
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for vertical_box_downscale.
//
// Streams random rows through the downscaler under many factor, format and
// row-length settings. An internal column-sum predictor forecasts every
// average and row_end marker. Each result is compared in order against the
// forecast. Both channels idle at random, the receiver backs up once for a
// long stretch, and configuration is rewritten between and inside groups.
// ----------------------------------------------------------------------------
module tb;

    import vbd_pkg::*;

    localparam logic [FormatWidth-1:0] FMT_S32 = 3'd5;
    localparam int ItemTarget = 1350;
    localparam int CycleLimit = 1000000;
    localparam int DrainCycles = 70;

    // Column-sum predictor and the queue of averages it expects.
    class sum_scoreboard;
        logic signed [SumWidth-1:0] sums [MaxRowElements];
        int unsigned col, row, written_upto;
        int unsigned factor, fmt, len;
        logic [SampleWidth-1:0] avg_q [$];
        bit end_q [$];
        bit failed;

        function new();
            col = 0; row = 0; written_upto = 0;
            factor = 2; fmt = FMT_U8; len = 4096;
            failed = 0;
        endfunction

        function int unsigned eff_len(int unsigned l);
            if (l == 0) return 1;
            if (l > MaxRowElements) return MaxRowElements;
            return l;
        endfunction

        function int unsigned eff_factor();
            return (factor == 0) ? 1 : factor;
        endfunction

        function void write_reg(logic [CfgIndexWidth-1:0] idx, int unsigned val);
            case (idx)
                REG_SHRINK_FACTOR: factor = val & 16'hFFFF;
                REG_SAMPLE_FORMAT: fmt = val & 3'h7;
                REG_ROW_LENGTH:    len = val & 13'h1FFF;
                default: ;
            endcase
        endfunction

        function int unsigned fmt_bits();
            if (fmt <= FMT_S8) return 8;
            if (fmt <= FMT_S16) return 16;
            return 32;
        endfunction

        function bit fmt_is_signed();
            return fmt == FMT_S8 || fmt == FMT_S16 || fmt >= FMT_S32;
        endfunction

        function longint decode(logic [SampleWidth-1:0] s);
            int unsigned w;
            longint unsigned m;
            longint unsigned u;
            w = fmt_bits();
            m = (64'd1 << w) - 1;
            u = s & m;
            if (fmt_is_signed() && u[w-1])
                return longint'(u) - longint'(64'd1 << w);
            return longint'(u);
        endfunction

        function logic [SampleWidth-1:0] round_avg(logic signed [SumWidth-1:0] s);
            longint t, q;
            longint unsigned mult, m, u;
            logic [31:0] p;
            int unsigned f, w;
            f = eff_factor();
            t = longint'(s) + longint'(f / 2);
            if (fmt == FMT_U8)
            begin
                mult = (64'd1 << 32) / (64'd256 * f);
                p = t[31:0] * mult[31:0];
                return SampleWidth'(p >> FixShift);
            end
            q = t / longint'(f);
            w = fmt_bits();
            m = (64'd1 << w) - 1;
            u = q & m;
            if (fmt_is_signed() && u[w-1])
                u = u | ~m;
            return u[SampleWidth-1:0];
        endfunction

        function void note_sample(logic [SampleWidth-1:0] smp);
            logic signed [SumWidth-1:0] s;
            bit last_col, last_row;
            int unsigned idx;
            idx = (col >= MaxRowElements) ? 0 : col;
            if (row == 0)
                s = SumWidth'(decode(smp));
            else
                s = sums[idx] + SumWidth'(decode(smp));
            sums[idx] = s;
            if (idx + 1 > written_upto) written_upto = idx + 1;
            last_col = (idx + 1) >= eff_len(len);
            last_row = (row + 1) >= eff_factor();
            if (last_row)
            begin
                avg_q.push_back(round_avg(s));
                end_q.push_back(last_col);
            end
            if (last_col)
            begin
                col = 0;
                row = last_row ? 0 : row + 1;
            end
            else
            begin
                col = idx + 1;
            end
        endfunction

        function void check(logic [SampleWidth-1:0] avg, logic re);
            logic [SampleWidth-1:0] e_avg;
            bit e_end;
            if (avg_q.size() == 0)
            begin
                $display("%0t: unexpected average %h row_end %b", $time, avg, re);
                failed = 1;
                return;
            end
            e_avg = avg_q.pop_front();
            e_end = end_q.pop_front();
            if (avg !== e_avg)
            begin
                $display("%0t: average expected %h actual %h", $time, e_avg, avg);
                failed = 1;
            end
            if (re !== e_end)
            begin
                $display("%0t: row_end expected %b actual %b", $time, e_end, re);
                failed = 1;
            end
        endfunction

        function int pending();
            return avg_q.size();
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [CfgIndexWidth-1:0]      cfg_index;
    logic [CfgDataWidth-1:0]       cfg_data;
    logic                          in_valid;
    logic                          in_ready;
    logic signed [SampleWidth-1:0] sample;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic signed [SampleWidth-1:0] average;
    logic                          row_end;

    sum_scoreboard sb;
    int unsigned cycles = 0;
    int unsigned hold_at;
    int unsigned hold_left = 0;
    int unsigned items;
    bit calm;

    vertical_box_downscale u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .average   (average),
        .row_end   (row_end)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // Receiver: check results, stall at random, back up once on request.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check(average, row_end);
            if (cycles == hold_at)
                hold_left = 400;
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= calm || ($urandom % 100) >= 27;
        end
    end

    function automatic logic [SampleWidth-1:0] pick_sample();
        if ($urandom % 5 == 0)
        begin
            case ($urandom % 8)
                0: return '0;
                1: return '1;
                2: return 33'h0_0000_0080;
                3: return 33'h0_0000_007F;
                4: return 33'h0_0000_8000;
                5: return 33'h0_0000_7FFF;
                6: return 33'h0_8000_0000;
                default: return 33'h0_7FFF_FFFF;
            endcase
        end
        return {1'($urandom), 32'($urandom)};
    endfunction

    // Drive one request and return at the edge where it is taken.
    task automatic send_item(logic [SampleWidth-1:0] v);
        if (!calm && ($urandom % 100) < 27)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_sample(v);
        items++;
    endtask

    task automatic wait_drained();
        while (sb.pending() > 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // Rewrite all three registers while the block is idle.
    task automatic configure(int unsigned f, int unsigned fm, int unsigned l);
        in_valid <= 1'b0;
        wait_drained();
        // Never let a grown row read entries that were never written.
        if (sb.row != 0 && sb.eff_len(l) > sb.written_upto)
            l = sb.written_upto;
        cfg_we    <= 1'b1;
        cfg_index <= REG_SHRINK_FACTOR;
        cfg_data  <= CfgDataWidth'(f);
        sb.write_reg(REG_SHRINK_FACTOR, f);
        @(posedge clk);
        cfg_index <= REG_SAMPLE_FORMAT;
        cfg_data  <= CfgDataWidth'(fm);
        sb.write_reg(REG_SAMPLE_FORMAT, fm);
        @(posedge clk);
        cfg_index <= REG_ROW_LENGTH;
        cfg_data  <= CfgDataWidth'(l);
        sb.write_reg(REG_ROW_LENGTH, l);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic finish_group();
        while (!(sb.row == 0 && sb.col == 0))
            send_item(pick_sample());
    endtask

    initial
    begin
        int unsigned f, fm, l, n;
        clk = 0; rst_n = 0; cfg_we = 0; cfg_index = '0; cfg_data = '0;
        in_valid = 0; sample = '0;
        hold_at = 0; items = 0; calm = 0;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every format at its bit extremes, two rows per group.
        for (int i = 0; i < 8; i++)
        begin
            configure(2, i, 1);
            send_item('1);
            send_item(33'h1 << (sb.fmt_bits() - 1));
        end
        // Zero factor and zero row length both act as one.
        configure(0, FMT_S16, 0);
        send_item(33'h1_0000_8001);
        send_item(33'h0_0000_7FFF);
        // Oversize row length clamps; shrink the row mid-stream to close it.
        configure(65535, FMT_U32, 8191);
        send_item('1);
        send_item('0);
        configure(1, FMT_U32, 1);
        send_item(33'h0_FFFF_FFFF);
        // Largest factor, then end the group early by lowering it.
        configure(65535, FMT_S32, 1);
        send_item(33'h0_8000_0000);
        send_item(33'h0_8000_0000);
        configure(1, FMT_S32, 1);
        send_item(33'h0_8000_0000);

        while (items < ItemTarget)
        begin
            case ($urandom % 10)
                0: f = 0;
                1, 2: f = 1;
                3, 4: f = 2;
                5: f = 3;
                6: f = 4;
                default: f = $urandom_range(1, 9);
            endcase
            fm = $urandom % 8;
            l = ($urandom % 5 == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
            configure(f, fm, l);
            calm = (items > 900 && items < 1100);
            n = sb.eff_factor() * sb.eff_len(l) * $urandom_range(1, 2);
            if ($urandom % 5 == 0)
            begin
                // Change settings partway through a group.
                repeat (n / 2) send_item(pick_sample());
                configure($urandom_range(0, 5), $urandom % 8, $urandom_range(0, 48));
                finish_group();
            end
            else
            begin
                for (int k = 0; k < n && items < ItemTarget; k++)
                begin
                    if (items == 700)
                    begin
                        in_valid <= 1'b0;
                        while (sb.pending() > 0) @(posedge clk);
                    end
                    // Back up the receiver while several results of a row remain.
                    if (hold_at == 0 && items > 400 && sb.row + 1 >= sb.eff_factor()
                        && sb.col + 4 <= sb.eff_len(sb.len))
                        hold_at = cycles + 2;
                    send_item(pick_sample());
                end
            end
        end
        calm = 0;

        in_valid <= 1'b0;
        wait_drained();
        if (!sb.failed && sb.pending() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
